[rtl/core/prtc_pkg.sv]
package prtc_pkg;

  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned PinW     = 16;
  localparam int unsigned ModeW    = 8;
  localparam int unsigned UnitW    = 8;
  localparam int unsigned RateW    = 32;

  // Reset value of the highest permitted GPIO start-up mode (pull-down input).
  localparam logic [ModeW-1:0] GpioModeRst = 8'd4;

  // Rows of the waveform tables.
  localparam int unsigned WaveKinds = 2;
  localparam logic        WavePwm   = 1'b0;
  localparam logic        WaveTimed = 1'b1;

  typedef enum logic [ReqTypeW-1:0] {
    ReqClear = 3'd0,
    ReqGpio  = 3'd1,
    ReqUart  = 3'd2,
    ReqPwm   = 3'd3,
    ReqTimed = 3'd4,
    AskUart  = 3'd5,
    AskPwm   = 3'd6,
    AskTimed = 3'd7
  } req_type_e;

  typedef struct packed {
    req_type_e        req_type;
    logic [PinW-1:0]  pin_first;
    logic [PinW-1:0]  pin_second;
    logic [ModeW-1:0] gpio_mode;
    logic [UnitW-1:0] unit_id;
    logic [RateW-1:0] rate_low;
    logic [RateW-1:0] rate_high;
    logic [RateW-1:0] query_value;
  } item_t;

endpackage

[rtl/core/pin_resource_table_checker.sv]
// Board resource plan checker. Each input beat is a clear, one plan entry (GPIO, UART or PWM or
// timed waveform) or one permission query, and each produces exactly one result beat carrying
// the running verdict (config_ok_o, sticky at 0 until a clear) and, for queries, the answer
// (query_allowed_o; 0 for clears and entries). Throughput is one beat per clock while results are
// taken: a beat is captured in an input register, checked against the pin map and the small UART
// and waveform tables by combinational compare logic, and moves to the result register once that
// register is empty or its result is being taken. Tables and pin map update when the beat leaves
// the input register, so back-to-back entries see each other. The result register decouples the
// two sides: input keeps flowing while a result waits, and stalls only when both the input and
// result registers are full and the result is not taken. The pin map and counters clear at reset
// and on a clear beat; table slots are read only below their fill count. Write highest_gpio_mode
// (cfg_data_i) only while no beat is in flight; cfg_ready_o is always high.
module pin_resource_table_checker #(
  parameter int unsigned PIN_COUNT   = 128,
  parameter int unsigned UART_SLOTS  = 3,
  parameter int unsigned PWM_SLOTS   = 4,
  parameter int unsigned TIMED_SLOTS = 2,
  parameter int unsigned WAVE_STORE  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prtc_pkg::ReqTypeW-1:0] req_type_i,
  input  logic [prtc_pkg::PinW-1:0]     pin_first_i,
  input  logic [prtc_pkg::PinW-1:0]     pin_second_i,
  input  logic [prtc_pkg::ModeW-1:0]    gpio_mode_i,
  input  logic [prtc_pkg::UnitW-1:0]    unit_id_i,
  input  logic [prtc_pkg::RateW-1:0]    rate_low_i,
  input  logic [prtc_pkg::RateW-1:0]    rate_high_i,
  input  logic [prtc_pkg::RateW-1:0]    query_value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          config_ok_o,
  output logic                          query_allowed_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [prtc_pkg::ModeW-1:0]    cfg_data_i
);
  import prtc_pkg::*;

  localparam int unsigned PinIdxW   = $clog2(PIN_COUNT);
  localparam int unsigned UartCntW  = $clog2(UART_SLOTS + 2);
  localparam int unsigned WaveCntW  = $clog2(WAVE_STORE + 2);

  // Handshake and input register.
  logic  s1_vld_q;
  item_t s1_q;
  logic  advance;
  logic  fire;

  // Result register.
  logic out_vld_q;
  logic ok_q;
  logic allowed_q;

  // Configuration.
  logic [ModeW-1:0] hgm_q;

  // Plan state.
  logic [PIN_COUNT-1:0] claimed_q, claimed_d;
  logic                 verdict_q, verdict_d;
  logic [UartCntW-1:0]  uart_cnt_q, uart_cnt_d;
  logic [WaveCntW-1:0]  wave_cnt_q [WaveKinds];
  logic [WaveCntW-1:0]  wave_cnt_d [WaveKinds];

  logic [UnitW-1:0] uart_port_q [UART_SLOTS];
  logic [RateW-1:0] uart_min_q  [UART_SLOTS];
  logic [RateW-1:0] uart_max_q  [UART_SLOTS];
  logic [UnitW-1:0] wave_chan_q [WaveKinds][WAVE_STORE];
  logic [RateW-1:0] wave_lim_q  [WaveKinds][WAVE_STORE];

  // Check logic.
  logic               wsel;
  logic [PinIdxW-1:0] pa_idx, pb_idx;
  logic               pa_free, pb_free;
  logic               rates_ok;
  logic               wave_lim_ok;
  logic [UART_SLOTS-1:0] uart_match;
  logic [WAVE_STORE-1:0] wave_match;
  logic               uart_dup, wave_dup;
  logic               uart_allow, wave_allow;
  logic               uart_wr, wave_wr;
  logic               ok, allowed;

  // Hold a beat in the input register while the result register is full and not taken.
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || advance;
  assign fire       = s1_vld_q && advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q.req_type    <= req_type_e'(req_type_i);
      s1_q.pin_first   <= pin_first_i;
      s1_q.pin_second  <= pin_second_i;
      s1_q.gpio_mode   <= gpio_mode_i;
      s1_q.unit_id     <= unit_id_i;
      s1_q.rate_low    <= rate_low_i;
      s1_q.rate_high   <= rate_high_i;
      s1_q.query_value <= query_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hgm_q <= GpioModeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hgm_q <= cfg_data_i;
    end
  end

  // Pin checks: out of range reads as taken.
  assign pa_idx  = s1_q.pin_first[PinIdxW-1:0];
  assign pb_idx  = s1_q.pin_second[PinIdxW-1:0];
  assign pa_free = (s1_q.pin_first < PinW'(PIN_COUNT)) && !claimed_q[pa_idx];
  assign pb_free = (s1_q.pin_second < PinW'(PIN_COUNT)) && !claimed_q[pb_idx]
                   && (s1_q.pin_second != s1_q.pin_first);

  assign rates_ok = (s1_q.rate_low != '0) && (s1_q.rate_low <= s1_q.rate_high);

  // Timed entries and queries use the second waveform row.
  assign wsel = (s1_q.req_type == ReqTimed) || (s1_q.req_type == AskTimed);
  assign wave_lim_ok = wsel ? (int'(wave_cnt_q[WaveTimed]) < int'(TIMED_SLOTS))
                            : (int'(wave_cnt_q[WavePwm]) < int'(PWM_SLOTS));

  // Table lookups: a slot counts only below the fill count; the lowest match wins.
  always_comb begin
    uart_allow = 1'b0;
    for (int k = UART_SLOTS - 1; k >= 0; k--) begin
      uart_match[k] = (int'(uart_cnt_q) > k) && (uart_port_q[k] == s1_q.unit_id);
      if (uart_match[k]) begin
        uart_allow = (s1_q.query_value >= uart_min_q[k]) && (s1_q.query_value <= uart_max_q[k]);
      end
    end
    uart_dup = |uart_match;
    if (int'(uart_cnt_q) > int'(UART_SLOTS)) begin
      uart_allow = 1'b0;
    end
  end

  always_comb begin
    wave_allow = 1'b0;
    for (int k = WAVE_STORE - 1; k >= 0; k--) begin
      wave_match[k] = (int'(wave_cnt_q[wsel]) > k) && (wave_chan_q[wsel][k] == s1_q.unit_id);
      if (wave_match[k]) begin
        wave_allow = s1_q.query_value <= wave_lim_q[wsel][k];
      end
    end
    wave_dup = |wave_match;
    if (int'(wave_cnt_q[wsel]) > int'(WAVE_STORE) || s1_q.query_value == '0) begin
      wave_allow = 1'b0;
    end
  end

  always_comb begin
    claimed_d  = claimed_q;
    uart_cnt_d = uart_cnt_q;
    wave_cnt_d = wave_cnt_q;
    uart_wr    = 1'b0;
    wave_wr    = 1'b0;
    ok         = 1'b1;
    allowed    = 1'b0;
    case (s1_q.req_type)
      ReqClear: begin
        claimed_d  = '0;
        uart_cnt_d = '0;
        for (int r = 0; r < WaveKinds; r++) begin
          wave_cnt_d[r] = '0;
        end
      end
      ReqGpio: begin
        ok = (s1_q.gpio_mode <= hgm_q) && pa_free;
        if (ok) begin
          claimed_d[pa_idx] = 1'b1;
        end
      end
      ReqUart: begin
        if (int'(uart_cnt_q) >= int'(UART_SLOTS)) begin
          uart_cnt_d = UartCntW'(UART_SLOTS + 1);
          ok         = 1'b0;
        end else begin
          // Receive pin is claimed before the transmit pin is checked.
          if (rates_ok && pa_free) begin
            claimed_d[pa_idx] = 1'b1;
          end
          if (rates_ok && pa_free && pb_free) begin
            claimed_d[pb_idx] = 1'b1;
          end
          ok         = rates_ok && pa_free && pb_free && !uart_dup;
          uart_wr    = 1'b1;
          uart_cnt_d = uart_cnt_q + UartCntW'(1);
        end
      end
      ReqPwm, ReqTimed: begin
        if (int'(wave_cnt_q[wsel]) >= int'(WAVE_STORE)) begin
          wave_cnt_d[wsel] = WaveCntW'(WAVE_STORE + 1);
          ok               = 1'b0;
        end else begin
          if (wave_lim_ok && s1_q.rate_high != '0 && pa_free) begin
            claimed_d[pa_idx] = 1'b1;
          end
          ok = wave_lim_ok && (s1_q.rate_high != '0) && pa_free && !wave_dup;
          wave_wr          = 1'b1;
          wave_cnt_d[wsel] = wave_cnt_q[wsel] + WaveCntW'(1);
        end
      end
      AskUart: begin
        allowed = uart_allow;
      end
      AskPwm, AskTimed: begin
        allowed = wave_allow;
      end
      default: begin
        allowed = 1'b0;
      end
    endcase
    // The verdict sticks at 0 until a clear.
    verdict_d = (s1_q.req_type == ReqClear) ? 1'b1 : (verdict_q && ok);
  end

  // Advance plan state and the result register together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      claimed_q  <= '0;
      verdict_q  <= 1'b1;
      uart_cnt_q <= '0;
      for (int r = 0; r < WaveKinds; r++) begin
        wave_cnt_q[r] <= '0;
      end
    end else if (fire) begin
      claimed_q  <= claimed_d;
      verdict_q  <= verdict_d;
      uart_cnt_q <= uart_cnt_d;
      wave_cnt_q <= wave_cnt_d;
    end
  end

  // Table slots: written at the fill count, no reset.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < UART_SLOTS; k++) begin
      if (fire && uart_wr && int'(uart_cnt_q) == k) begin
        uart_port_q[k] <= s1_q.unit_id;
        uart_min_q[k]  <= s1_q.rate_low;
        uart_max_q[k]  <= s1_q.rate_high;
      end
    end
    for (int k = 0; k < WAVE_STORE; k++) begin
      if (fire && wave_wr && int'(wave_cnt_q[wsel]) == k) begin
        wave_chan_q[wsel][k] <= s1_q.unit_id;
        wave_lim_q[wsel][k]  <= s1_q.rate_high;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ok_q      <= verdict_d;
      allowed_q <= allowed;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign config_ok_o     = ok_q;
  assign query_allowed_o = allowed_q;

  // A beat in the input register is never dropped while the result side stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !advance |=> s1_vld_q)
    else $error("input beat lost during result stall");

  // Clears and entries never report a permitted query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (s1_q.req_type == ReqClear || s1_q.req_type == ReqGpio ||
             s1_q.req_type == ReqUart || s1_q.req_type == ReqPwm ||
             s1_q.req_type == ReqTimed) |=> !query_allowed_o)
    else $error("query_allowed set on a non-query beat");

  // A clear always restores the verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.req_type == ReqClear |=> config_ok_o && verdict_q && uart_cnt_q == '0)
    else $error("clear did not restore plan state");

  // The verdict only rises on a clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !verdict_q && !(fire && s1_q.req_type == ReqClear) |=> !verdict_q)
    else $error("verdict rose without a clear");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import prtc_pkg::*;

  localparam int unsigned PinCount     = 128;
  localparam int unsigned UartSlots    = 3;
  localparam int unsigned PwmSlots     = 4;
  localparam int unsigned TimedSlots   = 2;
  localparam int unsigned WaveStore    = 4;
  localparam int unsigned PinIdxW      = $clog2(PinCount);
  // Drain wait covering the input register plus result register, with margin.
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic config_ok;
    logic query_allowed;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs; every input holds a known value from time 0
  // ---------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  item_t      item_d      = '0;
  logic       out_ready_i = 1'b1;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i  = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       config_ok_o;
  logic       query_allowed_o;
  logic       cfg_ready_o;

  pin_resource_table_checker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (item_d.req_type),
    .pin_first_i    (item_d.pin_first),
    .pin_second_i   (item_d.pin_second),
    .gpio_mode_i    (item_d.gpio_mode),
    .unit_id_i      (item_d.unit_id),
    .rate_low_i     (item_d.rate_low),
    .rate_high_i    (item_d.rate_high),
    .query_value_i  (item_d.query_value),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .config_ok_o    (config_ok_o),
    .query_allowed_o(query_allowed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(3_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Plan predictor: pin map, sticky verdict and the UART / waveform tables.
  // Table slots are only ever read below their fill count.
  // ---------------------------------------------------------------------------
  logic [PinCount-1:0] plan_pins;
  logic                plan_ok;
  logic [ModeW-1:0]    mode_limit;
  logic [UnitW-1:0]    uart_port_tab [UartSlots];
  logic [RateW-1:0]    uart_lo_tab   [UartSlots];
  logic [RateW-1:0]    uart_hi_tab   [UartSlots];
  int unsigned         uart_fill;
  logic [UnitW-1:0]    wave_chan_tab [WaveKinds][WaveStore];
  logic [RateW-1:0]    wave_max_tab  [WaveKinds][WaveStore];
  int unsigned         wave_fill     [WaveKinds];

  verdict_t    verdict_q[$];
  int unsigned fail_count      = 0;
  bit          quiet_sender    = 1'b0;
  bit          quiet_receiver  = 1'b0;
  int unsigned pressure_cycles = 0;

  function automatic void clear_plan();
    plan_pins = '0;
    plan_ok   = 1'b1;
    uart_fill = 0;
    wave_fill[WavePwm]   = 0;
    wave_fill[WaveTimed] = 0;
  endfunction

  function automatic bit reserve_pin(logic [PinW-1:0] pin);
    if (pin >= PinCount) return 1'b0;
    if (plan_pins[pin[PinIdxW-1:0]]) return 1'b0;
    plan_pins[pin[PinIdxW-1:0]] = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit store_uart(item_t it);
    int unsigned slot;
    int          k;
    bit          ok;
    slot = uart_fill;
    if (slot >= UartSlots) begin
      // Saturate one past the store; the table then answers nothing.
      uart_fill = UartSlots + 1;
      return 1'b0;
    end
    ok = (it.rate_low != '0) && (it.rate_low <= it.rate_high);
    // Receive pin first; it stays claimed if the transmit pin fails.
    if (ok) ok = reserve_pin(it.pin_first);
    if (ok) ok = reserve_pin(it.pin_second);
    for (k = 0; k < slot; k++) begin
      if (ok && uart_port_tab[k] == it.unit_id) ok = 1'b0;
    end
    uart_port_tab[slot] = it.unit_id;
    uart_lo_tab[slot]   = it.rate_low;
    uart_hi_tab[slot]   = it.rate_high;
    uart_fill           = slot + 1;
    return ok;
  endfunction

  function automatic bit store_wave(int unsigned kind, int unsigned slot_limit, item_t it);
    int unsigned slot;
    int          k;
    bit          ok;
    slot = wave_fill[kind];
    if (slot >= WaveStore) begin
      wave_fill[kind] = WaveStore + 1;
      return 1'b0;
    end
    // Entries past the kind's own limit still land in the store.
    ok = (slot < slot_limit) && (it.rate_high != '0);
    if (ok) ok = reserve_pin(it.pin_first);
    for (k = 0; k < slot; k++) begin
      if (ok && wave_chan_tab[kind][k] == it.unit_id) ok = 1'b0;
    end
    wave_chan_tab[kind][slot] = it.unit_id;
    wave_max_tab[kind][slot]  = it.rate_high;
    wave_fill[kind]           = slot + 1;
    return ok;
  endfunction

  function automatic bit ask_uart(logic [UnitW-1:0] port, logic [RateW-1:0] baud);
    int k;
    if (uart_fill > UartSlots) return 1'b0;
    for (k = 0; k < uart_fill; k++) begin
      if (uart_port_tab[k] == port) return (baud >= uart_lo_tab[k]) && (baud <= uart_hi_tab[k]);
    end
    return 1'b0;
  endfunction

  function automatic bit ask_wave(int unsigned kind, logic [UnitW-1:0] chan,
                                  logic [RateW-1:0] value);
    int k;
    if (wave_fill[kind] > WaveStore || value == '0) return 1'b0;
    for (k = 0; k < wave_fill[kind]; k++) begin
      if (wave_chan_tab[kind][k] == chan) return value <= wave_max_tab[kind][k];
    end
    return 1'b0;
  endfunction

  function automatic verdict_t apply_plan_item(item_t it);
    verdict_t v;
    bit       ok;
    ok              = 1'b1;
    v.query_allowed = 1'b0;
    case (it.req_type)
      ReqClear: clear_plan();
      ReqGpio: begin
        ok = it.gpio_mode <= mode_limit;
        if (ok) ok = reserve_pin(it.pin_first);
      end
      ReqUart:  ok = store_uart(it);
      ReqPwm:   ok = store_wave(WavePwm, PwmSlots, it);
      ReqTimed: ok = store_wave(WaveTimed, TimedSlots, it);
      AskUart:  v.query_allowed = ask_uart(it.unit_id, it.query_value);
      AskPwm:   v.query_allowed = ask_wave(WavePwm, it.unit_id, it.query_value);
      default:  v.query_allowed = ask_wave(WaveTimed, it.unit_id, it.query_value);
    endcase
    if (!ok) plan_ok = 1'b0;
    v.config_ok = plan_ok;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic item_t make_item(req_type_e kind, int unsigned pa, int unsigned pb,
                                      int unsigned mode, int unsigned unit,
                                      logic [RateW-1:0] lo, logic [RateW-1:0] hi,
                                      logic [RateW-1:0] q);
    item_t it;
    it.req_type    = kind;
    it.pin_first   = PinW'(pa);
    it.pin_second  = PinW'(pb);
    it.gpio_mode   = ModeW'(mode);
    it.unit_id     = UnitW'(unit);
    it.rate_low    = lo;
    it.rate_high   = hi;
    it.query_value = q;
    return it;
  endfunction

  // Any type, any payload; pins half the time within or just past the map.
  function automatic item_t noise_item();
    item_t it;
    it.req_type    = req_type_e'($urandom_range(0, 7));
    it.pin_first   = PinW'($urandom_range(0, 1) ? $urandom_range(0, PinCount + 7) : $urandom);
    it.pin_second  = PinW'($urandom_range(0, 1) ? $urandom_range(0, PinCount + 7) : $urandom);
    it.gpio_mode   = ModeW'($urandom);
    it.unit_id     = UnitW'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom);
    it.rate_low    = $urandom;
    it.rate_high   = $urandom;
    it.query_value = $urandom;
    return it;
  endfunction

  function automatic logic [PinW-1:0] free_pin(logic [PinW-1:0] avoid);
    logic [PinW-1:0] p;
    p = '0;
    repeat (64) begin
      p = PinW'($urandom_range(0, PinCount - 1));
      if (!plan_pins[p[PinIdxW-1:0]] && p != avoid) return p;
    end
    return p;
  endfunction

  // Entry of random kind; tidy ones pick free pins and legal ranges.
  function automatic item_t pick_entry(bit tidy);
    item_t            it;
    logic [RateW-1:0] a;
    logic [RateW-1:0] b;
    it          = noise_item();
    it.req_type = req_type_e'($urandom_range(ReqGpio, ReqTimed));
    if (tidy) begin
      it.pin_first  = free_pin('1);
      it.pin_second = free_pin(it.pin_first);
      it.gpio_mode  = ModeW'($urandom_range(0, mode_limit));
      it.unit_id    = UnitW'($urandom_range(0, 15));
      a = $urandom_range(0, 1) ? $urandom_range(1, 200000) : $urandom;
      b = $urandom_range(0, 1) ? $urandom_range(1, 200000) : $urandom;
      if (a > b) begin
        it.rate_low  = b;
        it.rate_high = a;
      end else begin
        it.rate_low  = a;
        it.rate_high = b;
      end
      if (it.rate_low == '0) it.rate_low = 1;
      if (it.rate_high == '0) it.rate_high = 1;
    end
    return it;
  endfunction

  // Query, mostly aimed at a stored unit and at the edges of its range.
  function automatic item_t pick_query();
    item_t            it;
    int unsigned      kind;
    int unsigned      slot;
    logic [RateW-1:0] lo;
    logic [RateW-1:0] hi;
    it = noise_item();
    if ($urandom_range(0, 2) == 0) begin
      it.req_type = AskUart;
      if (uart_fill > 0 && uart_fill <= UartSlots && $urandom_range(0, 4) != 0) begin
        slot       = $urandom_range(0, uart_fill - 1);
        it.unit_id = uart_port_tab[slot];
        lo         = uart_lo_tab[slot];
        hi         = uart_hi_tab[slot];
        case ($urandom_range(0, 4))
          0:       it.query_value = lo;
          1:       it.query_value = hi;
          2:       it.query_value = lo - 1;
          3:       it.query_value = hi + 1;
          default: it.query_value = $urandom_range(hi, lo);
        endcase
      end
    end else begin
      kind        = $urandom_range(0, 1) ? WaveTimed : WavePwm;
      it.req_type = (kind == WaveTimed) ? AskTimed : AskPwm;
      if (wave_fill[kind] > 0 && wave_fill[kind] <= WaveStore && $urandom_range(0, 4) != 0) begin
        slot       = $urandom_range(0, wave_fill[kind] - 1);
        it.unit_id = wave_chan_tab[kind][slot];
        hi         = wave_max_tab[kind][slot];
        case ($urandom_range(0, 4))
          0:       it.query_value = hi;
          1:       it.query_value = hi + 1;
          2:       it.query_value = '0;
          3:       it.query_value = 1;
          default: it.query_value = $urandom_range(1, hi);
        endcase
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Item channel: idle a random gap, raise valid, hold until the beat is taken.
  // Ready is sampled at the falling edge, where it is settled for the next rise.
  // ---------------------------------------------------------------------------
  task automatic offer_item(input item_t it);
    int unsigned gap;
    bit          took;
    gap = quiet_sender ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    item_d     <= it;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    verdict_q.push_back(apply_plan_item(it));
  endtask

  // Drop valid and wait until every expected result is back, then let the
  // pipeline go quiet.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (verdict_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode_limit(input logic [ModeW-1:0] limit);
    bit took;
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    mode_limit   = limit;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: compare each taken beat with the oldest expectation, then
  // draw how long to stall before the next one. A pending long hold-off from
  // the stimulus side overrides the draw.
  // ---------------------------------------------------------------------------
  initial begin : result_monitor
    bit          took;
    int unsigned hold_left;
    verdict_t    want;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      took = out_valid_o && out_ready_i;
      if (took) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat: config_ok %b query_allowed %b", $time,
                   config_ok_o, query_allowed_o);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (config_ok_o !== want.config_ok) begin
            $display("%0t: config_ok expected %b actual %b", $time, want.config_ok,
                     config_ok_o);
            fail_count++;
          end
          if (query_allowed_o !== want.query_allowed) begin
            $display("%0t: query_allowed expected %b actual %b", $time, want.query_allowed,
                     query_allowed_o);
            fail_count++;
          end
        end
      end
      @(posedge clk_i);
      if (hold_left > 0) hold_left--;
      else if (took) hold_left = quiet_receiver ? 0 : $urandom_range(0, 5);
      if (pressure_cycles > 0) begin
        hold_left       = pressure_cycles;
        pressure_cycles = 0;
      end
      out_ready_i <= (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  task automatic test_gpio_rules();
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    // Lowest pin and mode, then top pin at the reset mode limit.
    offer_item(make_item(ReqGpio, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqGpio, PinCount - 1, 0, int'(GpioModeRst), 0, 0, 0, 0));
    // Second claim of a pin drops the verdict for good.
    offer_item(make_item(ReqGpio, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqGpio, 5, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqClear, 'hFFFF, 'hFFFF, 'hFF, 'hFF, '1, '1, '1));
    // Pin just past the map.
    offer_item(make_item(ReqGpio, PinCount, 'hFFFF, int'(GpioModeRst), 'hFF, '1, '1, '1));
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    // Mode one above the limit.
    offer_item(make_item(ReqGpio, 7, 0, int'(GpioModeRst) + 1, 0, 0, 0, 0));
  endtask

  task automatic test_uart_rules();
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqUart, 10, 11, 0, 1, 9600, 115200, 0));
    offer_item(make_item(AskUart, 0, 0, 0, 1, 0, 0, 9599));
    offer_item(make_item(AskUart, 0, 0, 0, 1, 0, 0, 9600));
    offer_item(make_item(AskUart, 0, 0, 0, 1, 0, 0, 115201));
    offer_item(make_item(AskUart, 0, 0, 0, 2, 0, 0, 9600));
    // Zero minimum, then inverted range; both still take a slot.
    offer_item(make_item(ReqUart, 12, 13, 0, 2, 0, 5, 0));
    offer_item(make_item(ReqUart, 14, 15, 0, 3, 6, 5, 0));
    // Fourth entry overflows the table; queries then answer 0.
    offer_item(make_item(ReqUart, 16, 17, 0, 4, 1, 1, 0));
    offer_item(make_item(AskUart, 0, 0, 0, 1, 0, 0, 9600));
    // Duplicate port; transmit pin clashing with the receive pin.
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqUart, 20, 21, 0, 9, 1, '1, 0));
    offer_item(make_item(ReqUart, 22, 23, 0, 9, 1, '1, 0));
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqUart, 24, 24, 0, 1, 1, 1, 0));
  endtask

  task automatic test_wave_rules();
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqPwm, 30, 0, 0, 3, 0, 1000, 0));
    offer_item(make_item(AskPwm, 0, 0, 0, 3, 0, 0, 0));
    offer_item(make_item(AskPwm, 0, 0, 0, 3, 0, 0, 1000));
    offer_item(make_item(AskPwm, 0, 0, 0, 3, 0, 0, 1001));
    // Duplicate channel, then zero maximum.
    offer_item(make_item(ReqPwm, 31, 0, 0, 3, 0, 5, 0));
    offer_item(make_item(ReqPwm, 32, 0, 0, 4, 0, 0, 0));
    // Third timed entry breaks the limit but stays queryable.
    offer_item(make_item(ReqTimed, 40, 0, 0, 7, 0, 1, 0));
    offer_item(make_item(ReqTimed, 41, 0, 0, 8, 0, 1, 0));
    offer_item(make_item(ReqTimed, 42, 0, 0, 9, 0, '1, 0));
    offer_item(make_item(AskTimed, 0, 0, 0, 9, 0, 0, '1));
  endtask

  task automatic test_mode_limit();
    write_mode_limit('0);
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqGpio, 1, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqGpio, 2, 0, 1, 0, 0, 0, 0));
    write_mode_limit('1);
    offer_item(make_item(ReqClear, 0, 0, 0, 0, 0, 0, 0));
    offer_item(make_item(ReqGpio, 3, 0, 'hFF, 0, 0, 0, 0));
    write_mode_limit(GpioModeRst);
  endtask

  // Mostly clear / entries / queries sequences, with noise in between.
  task automatic test_random_plans(input int unsigned count);
    int unsigned sent;
    int unsigned n_entries;
    int unsigned n_queries;
    item_t       it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) quiet_sender = ~quiet_sender;
      if ($urandom_range(0, 99) < 15) quiet_receiver = ~quiet_receiver;
      if ($urandom_range(0, 4) == 0) begin
        offer_item(noise_item());
        sent++;
      end else begin
        it          = noise_item();
        it.req_type = ReqClear;
        offer_item(it);
        n_entries = $urandom_range(1, 8);
        n_queries = $urandom_range(2, 8);
        repeat (n_entries) offer_item(pick_entry($urandom_range(0, 9) != 0));
        repeat (n_queries) offer_item(pick_query());
        sent += 1 + n_entries + n_queries;
      end
    end
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // Hold the result side off for a long stretch while items keep coming, so
  // both registers fill and the input stalls.
  task automatic test_backpressure();
    settle_block();
    quiet_sender    = 1'b1;
    pressure_cycles = 60;
    repeat (24) offer_item($urandom_range(0, 1) ? pick_entry(1'b1) : pick_query());
    quiet_sender = 1'b0;
  endtask

  initial begin
    mode_limit = GpioModeRst;
    clear_plan();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_gpio_rules();
    test_uart_rules();
    test_wave_rules();
    test_mode_limit();
    test_random_plans(450);
    write_mode_limit('0);
    test_random_plans(450);
    write_mode_limit('1);
    test_backpressure();
    test_random_plans(450);
    write_mode_limit(ModeW'($urandom_range(1, 254)));
    test_random_plans(450);
    settle_block();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/prtc_pkg.sv
rtl/core/pin_resource_table_checker.sv
test/tb.sv
